// File: hw/rtl/ddo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the differential drive odometry core
// Word formats, register indexes, sequencer states, CORDIC constants.
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int POS_FRAC_BITS_DEF = 24;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int POS_W      = 48;
	localparam int TRAVEL_W   = 47;
	localparam int CORDIC_W   = 34;
	localparam int ATAN_IDX_W = 5;

	localparam logic [31:0] IPT_RESET = 32'd22789806;
	localparam logic [23:0] APT_RESET = 24'd45339;
	localparam logic [9:0]  PPI_RESET = 10'd100;
	localparam logic [11:0] ORG_RESET = 12'd450;

	localparam logic signed [CORDIC_W-1:0] TRIG_GAIN_START = 34'sd652032874;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INCHES_PER_TICK = 3'd0,
		REG_ANGLE_PER_TICK  = 3'd1,
		REG_PIXELS_PER_INCH = 3'd2,
		REG_ORIGIN_X        = 3'd3,
		REG_ORIGIN_Y        = 3'd4
	} cfg_reg_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_HEAD,
		S_TRAV,
		S_SETUP,
		S_ROT,
		S_XHI,
		S_XLO,
		S_XADD,
		S_YLO,
		S_YADD,
		S_PXHI,
		S_PXSUM,
		S_PYHI,
		S_PYSUM,
		S_DONE
	} ddo_state_t;

	typedef struct packed {
		logic signed [31:0] right_count;
		logic signed [31:0] left_count;
	} counts_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
		logic        [15:0] heading_angle;
	} pose_t;

	// arctangent of 2^-i as a binary angle, 2^32 per turn
	function automatic logic [29:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
		logic [29:0] v;
		unique case (idx)
			5'd0:    v = 30'd536870912;
			5'd1:    v = 30'd316933406;
			5'd2:    v = 30'd167458907;
			5'd3:    v = 30'd85004756;
			5'd4:    v = 30'd42667331;
			5'd5:    v = 30'd21354465;
			5'd6:    v = 30'd10679838;
			5'd7:    v = 30'd5340245;
			5'd8:    v = 30'd2670163;
			5'd9:    v = 30'd1335087;
			5'd10:   v = 30'd667544;
			5'd11:   v = 30'd333772;
			5'd12:   v = 30'd166886;
			5'd13:   v = 30'd83443;
			5'd14:   v = 30'd41722;
			5'd15:   v = 30'd20861;
			5'd16:   v = 30'd10430;
			5'd17:   v = 30'd5215;
			5'd18:   v = 30'd2608;
			5'd19:   v = 30'd1304;
			5'd20:   v = 30'd652;
			5'd21:   v = 30'd326;
			5'd22:   v = 30'd163;
			5'd23:   v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// File: hw/rtl/differential_drive_odometry_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_core: wheel odometry with CORDIC heading
// Integrates encoder counts into heading and position, reports pixel pose.
// ----------------------------------------------------------------------------
// usage
//   counts channel: absolute right/left encoder counts, one word per sample
//   pose channel: pixel x/y (saturated) and 16-bit binary heading
//   cfg port: plain register writes; write only while the core is idle,
//   the core itself does not enforce it
// datapath
//   a word passes through the CORDIC rotation loop, one iteration per
//   cycle, and one shared 32x32 multiplier reused for heading, travel,
//   position and pixel scaling
//   a new word is taken only once the previous result is in the output register
//   counts_stall stays high while a word is in flight
// reset
//   registers take their default values, heading and position go to zero
// back pressure
//   a finished pose waits in the output register; a new counts word is
//   still taken, and its result waits in the last step until pose drains
// ----------------------------------------------------------------------------
module differential_drive_odometry_core
	import ddo_pkg::*;
#(
	parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
	parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  counts_valid,
	output logic                  counts_stall,
	input  counts_t               counts,
	output logic                  pose_valid,
	input  logic                  pose_stall,
	output pose_t                 pose
);

	localparam int IterW    = $clog2(CORDIC_STEPS);
	localparam int TrvShift = 33 - POS_FRAC_BITS;

	ddo_state_t state_q, state_d;

	logic [31:0] ipt_q;
	logic [23:0] apt_q;
	logic [9:0]  ppi_q;
	logic [11:0] org_x_q, org_y_q;

	logic [31:0] last_right_q, last_left_q, heading_q, diff_q;
	logic [32:0] sum_mag_q;
	logic        sum_neg_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q;
	logic [TRAVEL_W-1:0] trav_q;

	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic        flip_q;
	logic [IterW-1:0] iter_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] product_q, hold_q;
	logic signed [15:0] pix_x_q, pix_y_q;

	pose_t pose_q;
	logic  out_valid_q;

	// combinational datapath
	logic [31:0] dr, dl;
	logic signed [32:0] sum_s;
	logic [64:0] prod65, tm;
	logic [31:0] ang;
	logic signed [CORDIC_W-1:0] xs, ys, atan_v;
	logic [CORDIC_W-1:0] x_abs, y_abs;
	logic [POS_W-1:0] px_abs, py_abs;
	logic [79:0] scl_sum;
	logic [POS_W-1:0] scl_r;
	logic signed [POS_W-1:0] pos_next;
	logic signed [POS_W-1:0] pos_cur;
	logic scl_neg;
	logic [63:0] pix_full;
	logic pix_done;

	assign dr     = counts.right_count - last_right_q;
	assign dl     = counts.left_count - last_left_q;
	assign sum_s  = 33'($signed(dr)) + 33'($signed(dl));
	assign prod65 = 65'(product_q) + (sum_mag_q[32] ? {1'b0, ipt_q, 32'b0} : 65'd0);
	assign tm     = prod65 >> TrvShift;
	assign ang    = (heading_q[31] ^ heading_q[30]) ? (heading_q ^ 32'h8000_0000) : heading_q;
	assign xs     = x_q >>> iter_q;
	assign ys     = y_q >>> iter_q;
	assign atan_v = $signed(CORDIC_W'(atan_turns(ATAN_IDX_W'(iter_q))));
	assign x_abs  = x_q[CORDIC_W-1] ? CORDIC_W'(-x_q) : CORDIC_W'(x_q);
	assign y_abs  = y_q[CORDIC_W-1] ? CORDIC_W'(-y_q) : CORDIC_W'(y_q);
	assign px_abs = pos_x_q[POS_W-1] ? POS_W'(-pos_x_q) : POS_W'(pos_x_q);
	assign py_abs = pos_y_q[POS_W-1] ? POS_W'(-pos_y_q) : POS_W'(pos_y_q);

	// (a << 24) + b, then >> 30
	assign scl_sum  = (80'(hold_q) << 24) + 80'(product_q);
	assign scl_r    = scl_sum[77:30];
	assign pix_full = hold_q + {product_q[31:0], 32'b0};
	assign pix_done = !out_valid_q || !pose_stall;

	always_comb begin
		logic signed [POS_W+1:0] delta, acc;
		if (state_q == S_XADD) begin
			pos_cur = pos_x_q;
			scl_neg = sum_neg_q ^ flip_q ^ y_q[CORDIC_W-1];
		end else begin
			pos_cur = pos_y_q;
			scl_neg = sum_neg_q ^ flip_q ^ x_q[CORDIC_W-1];
		end
		delta = $signed({2'b00, scl_r});
		if (scl_neg) begin
			delta = -delta;
		end
		acc = (POS_W+2)'(pos_cur) + delta;
		if (acc[POS_W+1:POS_W-1] == 3'b000 || acc[POS_W+1:POS_W-1] == 3'b111) begin
			pos_next = acc[POS_W-1:0];
		end else if (acc[POS_W+1]) begin
			pos_next = {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			pos_next = {1'b0, {(POS_W-1){1'b1}}};
		end
	end

	function automatic logic signed [15:0] to_pixel(input logic [63:0] full, input logic neg,
			input logic [11:0] origin);
		logic [63:0] m;
		logic [16:0] mc;
		logic signed [18:0] p;
		m  = full >> POS_FRAC_BITS;
		mc = (|m[63:17]) ? 17'h1ffff : m[16:0];
		p  = neg ? ($signed(19'(origin)) - $signed(19'(mc)))
		         : ($signed(19'(origin)) + $signed(19'(mc)));
		if (p > 19'sd32767) begin
			return 16'sh7fff;
		end else if (p < -19'sd32768) begin
			return 16'sh8000;
		end
		return p[15:0];
	endfunction

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (counts_valid) begin
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				mul_a   = diff_q;
				mul_b   = 32'(apt_q);
				state_d = S_TRAV;
			end
			S_TRAV: begin
				mul_a   = sum_mag_q[31:0];
				mul_b   = ipt_q;
				state_d = S_SETUP;
			end
			S_SETUP: state_d = S_ROT;
			S_ROT: begin
				if (iter_q == IterW'(CORDIC_STEPS - 1)) begin
					state_d = S_XHI;
				end
			end
			S_XHI: begin
				mul_a   = 32'(trav_q[46:24]);
				mul_b   = y_abs[31:0];
				state_d = S_XLO;
			end
			S_XLO: begin
				mul_a   = 32'(trav_q[23:0]);
				mul_b   = y_abs[31:0];
				state_d = S_XADD;
			end
			S_XADD: begin
				mul_a   = 32'(trav_q[46:24]);
				mul_b   = x_abs[31:0];
				state_d = S_YLO;
			end
			S_YLO: begin
				mul_a   = 32'(trav_q[23:0]);
				mul_b   = x_abs[31:0];
				state_d = S_YADD;
			end
			S_YADD: begin
				mul_a   = px_abs[31:0];
				mul_b   = 32'(ppi_q);
				state_d = S_PXHI;
			end
			S_PXHI: begin
				mul_a   = 32'(px_abs[47:32]);
				mul_b   = 32'(ppi_q);
				state_d = S_PXSUM;
			end
			S_PXSUM: begin
				mul_a   = py_abs[31:0];
				mul_b   = 32'(ppi_q);
				state_d = S_PYHI;
			end
			S_PYHI: begin
				mul_a   = 32'(py_abs[47:32]);
				mul_b   = 32'(ppi_q);
				state_d = S_PYSUM;
			end
			S_PYSUM: state_d = S_DONE;
			S_DONE: begin
				if (pix_done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipt_q   <= IPT_RESET;
			apt_q   <= APT_RESET;
			ppi_q   <= PPI_RESET;
			org_x_q <= ORG_RESET;
			org_y_q <= ORG_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_INCHES_PER_TICK: ipt_q   <= cfg_data;
				REG_ANGLE_PER_TICK:  apt_q   <= cfg_data[23:0];
				REG_PIXELS_PER_INCH: ppi_q   <= cfg_data[9:0];
				REG_ORIGIN_X:        org_x_q <= cfg_data[11:0];
				REG_ORIGIN_Y:        org_y_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// odometry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_right_q <= '0;
			last_left_q  <= '0;
			heading_q    <= '0;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
		end else begin
			if (state_q == S_IDLE && counts_valid) begin
				last_right_q <= counts.right_count;
				last_left_q  <= counts.left_count;
			end
			if (state_q == S_TRAV) begin
				heading_q <= heading_q + product_q[31:0];
			end
			if (state_q == S_XADD) begin
				pos_x_q <= pos_next;
			end
			if (state_q == S_YADD) begin
				pos_y_q <= pos_next;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		product_q <= 64'(mul_a) * 64'(mul_b);
		unique case (state_q)
			S_IDLE: begin
				diff_q    <= dl - dr;
				sum_neg_q <= sum_s[32];
				sum_mag_q <= sum_s[32] ? 33'(-sum_s) : 33'(sum_s);
			end
			S_SETUP: begin
				trav_q <= (|tm[64:47]) ? {TRAVEL_W{1'b1}} : tm[46:0];
				flip_q <= heading_q[31] ^ heading_q[30];
				x_q    <= TRIG_GAIN_START;
				y_q    <= '0;
				z_q    <= CORDIC_W'($signed(ang));
				iter_q <= '0;
			end
			S_ROT: begin
				if (!z_q[CORDIC_W-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_v;
				end
				iter_q <= iter_q + 1'b1;
			end
			S_XLO, S_YLO, S_PXHI, S_PYHI: hold_q <= product_q;
			S_PXSUM: pix_x_q <= to_pixel(pix_full, pos_x_q[POS_W-1], org_x_q);
			S_PYSUM: pix_y_q <= to_pixel(pix_full, pos_y_q[POS_W-1], org_y_q);
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && pix_done) begin
			out_valid_q <= 1'b1;
		end else if (!pose_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && pix_done) begin
			pose_q.pixel_x       <= pix_x_q;
			pose_q.pixel_y       <= pix_y_q;
			pose_q.heading_angle <= heading_q[31:16];
		end
	end

	assign counts_stall = (state_q != S_IDLE);
	assign pose_valid   = out_valid_q;
	assign pose         = pose_q;

endmodule

// File: hw/rtl/ddo_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_checker: port-level checks for the odometry core
// Watches the counts and pose channels and the busy window between them.
// ----------------------------------------------------------------------------
module ddo_checker
	import ddo_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    counts_valid,
	input logic    counts_stall,
	input logic    pose_valid,
	input logic    pose_stall,
	input pose_t   pose
);

	// an accepted word keeps the core busy on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		counts_valid && !counts_stall |=> counts_stall)
	else $error("core not busy after accepting a counts word");

	// busy only starts from an accepted word
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(counts_stall) |-> $past(counts_valid))
	else $error("core went busy without a counts word");

	// a new pose only comes out of a busy core
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pose_valid) |-> $past(counts_stall))
	else $error("pose word without work in flight");

	// held pose word stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		pose_valid && pose_stall |=> pose_valid && $stable(pose))
	else $error("stalled pose word changed");

endmodule

bind differential_drive_odometry_core ddo_checker u_ddo_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.counts_valid (counts_valid),
	.counts_stall (counts_stall),
	.pose_valid   (pose_valid),
	.pose_stall   (pose_stall),
	.pose         (pose)
);

// File: tb/sv/differential_drive_odometry_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_core_tb: self-checking bench for the odometry core
// Sends encoder count words with random gaps while the pose side stalls at
// random, both in most runs. An in-bench fixed point model of heading, travel,
// CORDIC rotation and pixel scaling predicts each pose word, compared field by
// field. Directed runs cover count extremes, register edges, heading quadrant
// boundaries and travel saturation; random runs cover several register sets.
// ----------------------------------------------------------------------------
module differential_drive_odometry_core_tb;
	import ddo_pkg::*;

	localparam int ROT_STEPS = 16;
	localparam int FRAC_BITS = 24;
	localparam longint TRIG_START = 64'sd652032874;
	localparam longint POS_TOP = 64'sd140737488355327;
	localparam bit [63:0] TRAVEL_TOP = 64'd140737488355327;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 60;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  counts_valid;
	logic                  counts_stall;
	counts_t               counts_word;
	logic                  pose_valid;
	logic                  pose_stall;
	pose_t                 pose_word;

	differential_drive_odometry_core #(
		.CORDIC_STEPS(ROT_STEPS),
		.POS_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.counts_valid(counts_valid),
		.counts_stall(counts_stall),
		.counts(counts_word),
		.pose_valid(pose_valid),
		.pose_stall(pose_stall),
		.pose(pose_word)
	);

	// odometry model registers and state
	bit [31:0] tick_len;
	bit [23:0] tick_turn;
	bit [9:0]  scale_ppi;
	bit [11:0] org_x;
	bit [11:0] org_y;
	bit [31:0] prev_right;
	bit [31:0] prev_left;
	bit [31:0] bearing;
	longint    east;
	longint    north;

	// arctangent of 2^-i, 2^32 per turn
	longint arc_step [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	pose_t poses_due[$];
	int    errors;
	int    cycles = 0;
	bit    idle_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("differential_drive_odometry_core_tb: errors");
			$finish;
		end
	end

	function automatic bit [63:0] magnitude(input longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint clamp_pos(input longint v);
		if (v > POS_TOP)
			return POS_TOP;
		if (v < -POS_TOP - 1)
			return -POS_TOP - 1;
		return v;
	endfunction

	function automatic void cordic_rotate(input bit [31:0] ang, output longint cos_q,
		output longint sin_q);
		bit [31:0] a;
		bit        flip;
		longint    x;
		longint    y;
		longint    z;
		longint    xs;
		longint    ys;
		flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
		a = flip ? ang - 32'h8000_0000 : ang;
		z = $signed(a);
		x = TRIG_START;
		y = 0;
		for (int i = 0; i < ROT_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - arc_step[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + arc_step[i];
			end
		end
		cos_q = flip ? -x : x;
		sin_q = flip ? -y : y;
	endfunction

	// travel times q30 trig, truncated toward zero
	function automatic longint scale_q30(input longint t, input longint s);
		bit [63:0] ut;
		bit [63:0] us;
		bit [63:0] a;
		bit [63:0] b;
		bit [63:0] r;
		ut = magnitude(t);
		us = magnitude(s);
		a = (ut >> 24) * us;
		b = (ut & 64'hFF_FFFF) * us;
		r = (a >> 6) + ((((a & 64'd63) << 24) + b) >> 30);
		return ((t < 0) != (s < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [15:0] pixel_of(input longint p, input bit [11:0] org);
		bit [63:0] m;
		longint    q;
		m = (magnitude(p) * 64'(scale_ppi)) >> FRAC_BITS;
		q = longint'(org) + ((p < 0) ? -longint'(m) : longint'(m));
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[15:0];
	endfunction

	function automatic pose_t odometry_step(input bit [31:0] r_cnt, input bit [31:0] l_cnt);
		bit [31:0] dr_raw;
		bit [31:0] dl_raw;
		bit [63:0] turn;
		bit [63:0] tm;
		longint    dr;
		longint    dl;
		longint    sum;
		longint    travel;
		longint    cos_q;
		longint    sin_q;
		pose_t     pose_new;
		dr_raw = r_cnt - prev_right;
		dl_raw = l_cnt - prev_left;
		dr = $signed(dr_raw);
		dl = $signed(dl_raw);
		sum = dr + dl;
		turn = dl - dr;
		turn = turn * tick_turn;
		bearing = bearing + turn[31:0];
		tm = (magnitude(sum) * 64'(tick_len)) >> (33 - FRAC_BITS);
		if (tm > TRAVEL_TOP)
			tm = TRAVEL_TOP;
		travel = (sum < 0) ? -longint'(tm) : longint'(tm);
		cordic_rotate(bearing, cos_q, sin_q);
		east = clamp_pos(east + scale_q30(travel, sin_q));
		north = clamp_pos(north + scale_q30(travel, cos_q));
		prev_right = r_cnt;
		prev_left = l_cnt;
		pose_new.pixel_x = pixel_of(east, org_x);
		pose_new.pixel_y = pixel_of(north, org_y);
		pose_new.heading_angle = bearing[31:16];
		return pose_new;
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_INCHES_PER_TICK: tick_len = value;
			REG_ANGLE_PER_TICK:  tick_turn = value[23:0];
			REG_PIXELS_PER_INCH: scale_ppi = value[9:0];
			REG_ORIGIN_X:        org_x = value[11:0];
			REG_ORIGIN_Y:        org_y = value[11:0];
			default: ;
		endcase
	endtask

	task automatic push_counts(input logic [31:0] r_cnt, input logic [31:0] l_cnt);
		int gap;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			counts_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		counts_valid <= 1'b1;
		counts_word <= '{right_count: r_cnt, left_count: l_cnt};
		do @(posedge clk); while (counts_stall);
		poses_due.push_back(odometry_step(r_cnt, l_cnt));
	endtask

	// drop valid and wait until every pose word has come back
	task automatic settle();
		@(negedge clk);
		counts_valid <= 1'b0;
		while (poses_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic flag(input string what, input int want, input int got);
		if (errors < 10)
			$display("pose mismatch on %s: expected %0d, got %0d", what, want, got);
		errors++;
	endtask

	task automatic check_pose(input pose_t got);
		pose_t want;
		if (poses_due.size() == 0) begin
			if (errors < 10)
				$display("pose word with nothing pending: x %0d y %0d heading %0d",
					got.pixel_x, got.pixel_y, got.heading_angle);
			errors++;
		end else begin
			want = poses_due.pop_front();
			if (got.pixel_x !== want.pixel_x)
				flag("pixel_x", want.pixel_x, got.pixel_x);
			if (got.pixel_y !== want.pixel_y)
				flag("pixel_y", want.pixel_y, got.pixel_y);
			if (got.heading_angle !== want.heading_angle)
				flag("heading_angle", want.heading_angle, got.heading_angle);
		end
	endtask

	initial begin : pose_sink
		int hold;
		hold = 0;
		pose_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (pose_valid && !pose_stall) begin
				check_pose(pose_word);
				hold = idle_on ? $urandom_range(0, 7) : 0;
			end else if (pose_valid && hold > 0) begin
				hold--;
			end
			@(negedge clk);
			pose_stall <= (hold > 0);
		end
	end

	function automatic logic [31:0] extreme_count();
		case ($urandom_range(0, 3))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	task automatic test_default_scale();
		idle_on = 1'b0;
		push_counts(32'd0, 32'd0);
		push_counts(32'd100, 32'd100);
		push_counts(32'd50, 32'd150);
		push_counts(32'h8000_0000, 32'h8000_0000);
		push_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF);
	endtask

	task automatic test_register_edges();
		settle();
		idle_on = 1'b1;
		// zero scale, junk above the register width
		write_reg(REG_PIXELS_PER_INCH, 32'hFFFF_FC00);
		push_counts(prev_right + 32'd1000, prev_left + 32'd1000);
		push_counts(prev_right - 32'd300, prev_left + 32'd700);
		settle();
		write_reg(REG_PIXELS_PER_INCH, 32'h1234_57FF);
		write_reg(REG_INCHES_PER_TICK, 32'd0);
		push_counts(prev_right + 32'd5000, prev_left + 32'd5000);
		settle();
		write_reg(REG_INCHES_PER_TICK, 32'd1);
		write_reg(REG_ANGLE_PER_TICK, 32'hABFF_FFFF);
		write_reg(REG_ORIGIN_X, 32'hFFFF_FFFF);
		write_reg(REG_ORIGIN_Y, 32'hFFFF_F000);
		push_counts(prev_right + 32'd1, prev_left + 32'd2);
		push_counts(prev_right + 32'h0010_0000, prev_left - 32'h0010_0000);
		push_counts(prev_right - 32'd7, prev_left + 32'd3);
	endtask

	task automatic test_quadrant_edges();
		settle();
		idle_on = 1'b1;
		write_reg(REG_ANGLE_PER_TICK, 32'd1);
		write_reg(REG_INCHES_PER_TICK, 32'd22789806);
		write_reg(REG_PIXELS_PER_INCH, 32'd100);
		write_reg(REG_ORIGIN_X, 32'd2048);
		write_reg(REG_ORIGIN_Y, 32'd2048);
		// bring the heading back to zero
		push_counts(prev_right, prev_left - bearing);
		settle();
		write_reg(REG_ANGLE_PER_TICK, 32'h0040_0000);
		// quarter turn per word, with travel
		repeat (5)
			push_counts(prev_right - 32'd78, prev_left + 32'd178);
	endtask

	task automatic test_random_paths();
		int          pick;
		logic [31:0] r_cnt;
		logic [31:0] l_cnt;
		for (int ph = 0; ph < 6; ph++) begin
			settle();
			idle_on = (ph != 1) && (ph != 4);
			case (ph)
				0: begin
					write_reg(REG_INCHES_PER_TICK, 32'd22789806);
					write_reg(REG_ANGLE_PER_TICK, 32'd45339);
					write_reg(REG_PIXELS_PER_INCH, 32'd100);
					write_reg(REG_ORIGIN_X, 32'd450);
					write_reg(REG_ORIGIN_Y, 32'd450);
				end
				1: begin
					write_reg(REG_INCHES_PER_TICK, 32'd1);
					write_reg(REG_ANGLE_PER_TICK, 32'd0);
					write_reg(REG_PIXELS_PER_INCH, 32'd1);
					write_reg(REG_ORIGIN_X, 32'd0);
					write_reg(REG_ORIGIN_Y, 32'd0);
				end
				2: begin
					write_reg(REG_INCHES_PER_TICK, 32'hFFFF_FFFF);
					write_reg(REG_ANGLE_PER_TICK, 32'h00FF_FFFF);
					write_reg(REG_PIXELS_PER_INCH, 32'd1023);
					write_reg(REG_ORIGIN_X, 32'd4095);
					write_reg(REG_ORIGIN_Y, 32'd4095);
				end
				default: begin
					write_reg(REG_INCHES_PER_TICK, $urandom_range(1, 32'h0400_0000));
					write_reg(REG_ANGLE_PER_TICK, $urandom());
					write_reg(REG_PIXELS_PER_INCH,
						{22'($urandom()), 10'($urandom_range(1, 1023))});
					write_reg(REG_ORIGIN_X, $urandom());
					write_reg(REG_ORIGIN_Y, $urandom());
				end
			endcase
			repeat (100) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					r_cnt = prev_right + 32'(int'($urandom_range(0, 400)) - 200);
					l_cnt = prev_left + 32'(int'($urandom_range(0, 400)) - 200);
				end else if (pick < 85) begin
					r_cnt = prev_right + 32'(int'($urandom_range(0, 131072)) - 65536);
					l_cnt = prev_left + 32'(int'($urandom_range(0, 131072)) - 65536);
				end else if (pick < 95) begin
					r_cnt = $urandom();
					l_cnt = $urandom();
				end else begin
					r_cnt = extreme_count();
					l_cnt = extreme_count();
				end
				push_counts(r_cnt, l_cnt);
			end
		end
	endtask

	task automatic test_travel_saturation();
		settle();
		idle_on = 1'b1;
		write_reg(REG_INCHES_PER_TICK, 32'hFFFF_FFFF);
		write_reg(REG_PIXELS_PER_INCH, 32'd1023);
		write_reg(REG_ANGLE_PER_TICK, 32'h0020_0000);
		write_reg(REG_ORIGIN_X, 32'd2048);
		write_reg(REG_ORIGIN_Y, 32'd2048);
		// largest backward travel, then largest forward travel
		repeat (4)
			push_counts(prev_right + 32'h8000_0000, prev_left + 32'h8000_0001);
		repeat (4)
			push_counts(prev_right + 32'h7FFF_FFFF, prev_left + 32'h7FFF_FFFF);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_INCHES_PER_TICK;
		cfg_data = '0;
		counts_valid = 1'b0;
		counts_word = '0;
		idle_on = 1'b0;
		errors = 0;
		tick_len = 32'd22789806;
		tick_turn = 24'd45339;
		scale_ppi = 10'd100;
		org_x = 12'd450;
		org_y = 12'd450;
		prev_right = '0;
		prev_left = '0;
		bearing = '0;
		east = 0;
		north = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		test_default_scale();
		test_register_edges();
		test_quadrant_edges();
		test_random_paths();
		test_travel_saturation();
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && poses_due.size() == 0)
			$display("differential_drive_odometry_core_tb: clean");
		else
			$display("differential_drive_odometry_core_tb: errors");
		$finish;
	end

endmodule
